// ----- rtl/core/rdp_pkg.sv -----
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared types and constants of the reuse distance predictor: word layouts,
// operation and register codes, hash constants and controller handshakes.
// ----------------------------------------------------------------------------
package rdp_pkg;

  // Fixed field widths
  localparam int PC_W    = 64;
  localparam int SIG_W   = 11;
  localparam int STAMP_W = 8;
  localparam int GRAN_W  = 5;
  localparam int ETR_W   = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Operation codes
  localparam logic [1:0] FUNC_TRAIN   = 2'd0;
  localparam logic [1:0] FUNC_PREDICT = 2'd1;
  localparam logic [1:0] FUNC_BYPASS  = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_CORE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANULARITY = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INF_ETR     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ETR     = 8'd3;

  // Register reset values
  localparam logic              MULTI_CORE_RST  = 1'b0;
  localparam logic [GRAN_W-1:0] GRANULARITY_RST = 5'd8;
  localparam logic [ETR_W-1:0]  INF_ETR_RST     = 8'd15;
  localparam logic [ETR_W-1:0]  MAX_ETR_RST     = 8'd15;

  // Signature hash and training step
  localparam logic [PC_W-1:0] HASH_POLY     = 64'd3988292384;
  localparam int              HASH_ROUNDS   = 3;
  localparam int              STEP_MIN_DIFF = 16;

  typedef struct packed {
    logic [1:0]         func;
    logic [SIG_W-1:0]   signature;
    logic               sample_hit;
    logic               evict;
    logic [STAMP_W-1:0] curr_stamp;
    logic [STAMP_W-1:0] last_stamp;
    logic [PC_W-1:0]    pc;
    logic               was_hit;
    logic [1:0]         core_id;
    logic               line_valid;
  } rdp_in_t;

  typedef struct packed {
    logic [ETR_W-1:0] prediction;
    logic             bypass;
  } rdp_out_t;

  typedef struct packed {
    logic              multi_core;
    logic [GRAN_W-1:0] granularity;
    logic [ETR_W-1:0]  inf_etr;
    logic [ETR_W-1:0]  max_etr;
  } rdp_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic hash_en;
    logic mulq_en;
    logic mod_en;
    logic rd_en;
    logic wr_train;
    logic div_start;
    logic out_load;
  } rdp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] item_func;
    logic       clear_last;
    logic       div_done;
    logic       out_free;
  } rdp_sts_t;

endpackage

// ----- rtl/core/rdp_div.sv -----
// ----------------------------------------------------------------------------
// rdp_div
// Restoring divider, one quotient bit per cycle: counter value over the
// aging granularity.
// ----------------------------------------------------------------------------
module rdp_div #(
  parameter int CNT_W = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [CNT_W-1:0]          dividend,
  input  logic [rdp_pkg::GRAN_W-1:0] divisor,
  output logic                      done,
  output logic [CNT_W-1:0]          quotient
);
  import rdp_pkg::*;

  localparam int STEP_W = $clog2(CNT_W + 1);

  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  quo_r;
  logic [GRAN_W-1:0] rem_r;
  logic [GRAN_W-1:0] dvs_r;
  logic [GRAN_W:0]   shift_val;
  logic [GRAN_W:0]   diff_val;
  logic              ge;
  logic [GRAN_W-1:0] rem_nxt;

  // Shift in one dividend bit and try the subtraction
  always_comb begin
    shift_val = {rem_r, quo_r[CNT_W-1]};
    diff_val  = shift_val - {1'b0, dvs_r};
    ge        = shift_val >= {1'b0, dvs_r};
    rem_nxt   = ge ? diff_val[GRAN_W-1:0] : shift_val[GRAN_W-1:0];
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(CNT_W);
    end else if (step_r != '0) begin
      step_r <= step_r - 1'b1;
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (step_r != '0) begin
      quo_r <= {quo_r[CNT_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = (step_r == '0);
  assign quotient = quo_r;

endmodule

// ----- rtl/core/rdp_dp.sv -----
// ----------------------------------------------------------------------------
// rdp_dp
// Datapath: item register, signature hash, index reduction, counter table,
// training update, ETR divider and output register.
// ----------------------------------------------------------------------------
module rdp_dp #(
  parameter int ENTRIES        = 2048,
  parameter int COUNTER_BITS   = 7,
  parameter int SIGNATURE_BITS = 11,
  parameter int TIMESTAMP_BITS = 8,
  parameter int RD_MARGIN      = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rdp_pkg::rdp_in_t  in_data,
  input  rdp_pkg::rdp_cfg_t cfg,
  input  rdp_pkg::rdp_cmd_t cmd,
  output rdp_pkg::rdp_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output rdp_pkg::rdp_out_t out_data
);
  import rdp_pkg::*;

  localparam int CNT_W = COUNTER_BITS;
  localparam int TS_W  = TIMESTAMP_BITS;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int KEY_W = (SIGNATURE_BITS > SIG_W) ? SIGNATURE_BITS : SIG_W;
  localparam int PRD_W = KEY_W + IDX_W + 1;
  localparam int CMP_W = CNT_W + TS_W;
  localparam int QW    = CNT_W + ETR_W;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / ENTRIES);
  localparam logic [CNT_W-1:0] CMAX = '1;
  localparam logic [CNT_W-1:0] RMAX = CNT_W'((1 << CNT_W) - 1 - RD_MARGIN);

  rdp_in_t           item_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  q_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W:0]    rd_data_r;
  logic [IDX_W-1:0]  clr_addr_r;
  logic              out_valid_r;
  rdp_out_t          out_data_r;
  logic [CNT_W:0]    tbl_mem [ENTRIES];

  logic [PC_W-1:0]     hash_x;
  logic [KEY_W-1:0]    key_nxt;
  logic [KEY_W+31:0]   prod;
  logic [PRD_W-1:0]    qe;
  logic [PRD_W-1:0]    rem;
  logic [PRD_W-1:0]    red;
  logic                trained;
  logic [CNT_W-1:0]    cnt;
  logic [TS_W-1:0]     sample;
  logic [CMP_W-1:0]    sample_w;
  logic [CMP_W-1:0]    cnt_w;
  logic                upd_en;
  logic [CNT_W-1:0]    upd_cnt;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [CNT_W:0]      wr_dat;
  logic                div_done;
  logic [CNT_W-1:0]    quo;
  logic [QW-1:0]       quo_w;
  logic [GRAN_W-1:0]   eff_gran;
  logic                above;
  rdp_out_t            out_nxt;

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // Fold pc into the signature and run the shift-xor rounds; train items keep their own signature
  always_comb begin
    if (cfg.multi_core) begin
      hash_x = {item_r.pc[PC_W-4:0], 1'b0, item_r.core_id};
    end else begin
      hash_x = {item_r.pc[PC_W-3:0], item_r.was_hit, 1'b0};
    end
    for (int r = 0; r < HASH_ROUNDS; r++) begin
      hash_x = hash_x[0] ? ((hash_x >> 1) ^ HASH_POLY) : (hash_x >> 1);
    end
    if (item_r.func == FUNC_TRAIN) begin
      key_nxt = KEY_W'(item_r.signature);
    end else begin
      key_nxt = KEY_W'(hash_x[SIGNATURE_BITS-1:0]);
    end
  end

  // Reduce key modulo the table size: reciprocal estimate, then one correction
  always_comb begin
    prod = (KEY_W + 32)'(key_r) * (KEY_W + 32)'(RECIP);
    qe   = PRD_W'(q_r) * PRD_W'(ENTRIES);
    rem  = PRD_W'(key_r) - qe;
    red  = (rem >= PRD_W'(ENTRIES)) ? (rem - PRD_W'(ENTRIES)) : rem;
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_en) begin
      key_r <= key_nxt;
    end
    if (cmd.mulq_en) begin
      q_r <= prod[KEY_W+31:32];
    end
    if (cmd.mod_en) begin
      idx_r <= red[IDX_W-1:0];
    end
  end

  // Training update of one entry
  always_comb begin
    trained  = rd_data_r[CNT_W];
    cnt      = rd_data_r[CNT_W-1:0];
    sample   = item_r.curr_stamp[TS_W-1:0] - item_r.last_stamp[TS_W-1:0];
    sample_w = CMP_W'(sample);
    cnt_w    = CMP_W'(cnt);
    upd_en   = 1'b0;
    upd_cnt  = cnt;
    if (item_r.sample_hit) begin
      if (sample_w <= CMP_W'(CMAX)) begin
        upd_en = 1'b1;
        if (!trained) begin
          upd_cnt = CNT_W'(sample);
        end else if (sample_w > cnt_w && (sample_w - cnt_w) >= CMP_W'(STEP_MIN_DIFF)) begin
          upd_cnt = (cnt == CMAX) ? CMAX : cnt + 1'b1;
        end else if (sample_w < cnt_w && (cnt_w - sample_w) >= CMP_W'(STEP_MIN_DIFF)) begin
          upd_cnt = cnt - 1'b1;
        end
      end
    end else if (item_r.evict) begin
      upd_en = 1'b1;
      if (!trained) begin
        upd_cnt = CMAX;
      end else if (cnt != CMAX) begin
        upd_cnt = cnt + 1'b1;
      end
    end
  end

  // Table write port: clearing sweep or training
  always_comb begin
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_dat  = '0;
    end else begin
      wr_en   = cmd.wr_train && upd_en;
      wr_addr = idx_r;
      wr_dat  = {1'b1, upd_cnt};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_dat;
    end
    if (cmd.rd_en) begin
      rd_data_r <= tbl_mem[idx_r];
    end
  end

  // Advance the clearing address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign eff_gran = (cfg.granularity == '0) ? GRAN_W'(1) : cfg.granularity;

  rdp_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cnt),
    .divisor  (eff_gran),
    .done     (div_done),
    .quotient (quo)
  );

  // Form the prediction or bypass word
  always_comb begin
    quo_w   = QW'(quo);
    above   = cnt > RMAX;
    out_nxt = '0;
    if (item_r.func == FUNC_PREDICT) begin
      if (!trained) begin
        out_nxt.prediction = cfg.multi_core ? cfg.inf_etr : '0;
      end else if (above) begin
        out_nxt.prediction = cfg.inf_etr;
      end else if (quo_w > QW'(255)) begin
        out_nxt.prediction = '1;
      end else begin
        out_nxt.prediction = quo_w[ETR_W-1:0];
      end
    end else begin
      out_nxt.bypass = item_r.line_valid && trained &&
                       (above || quo_w > QW'(cfg.max_etr));
    end
  end

  // Output register: load a word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.item_func  = item_r.func;
  assign sts.clear_last = (clr_addr_r == IDX_W'(ENTRIES - 1));
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

// ----- rtl/core/rdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdp_ctrl
// Controller: sequences the table clear, then each item through hash,
// index reduction, table read, update or divide, and result hand-off.
// ----------------------------------------------------------------------------
module rdp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_stall,
  input  rdp_pkg::rdp_sts_t sts,
  output rdp_pkg::rdp_cmd_t cmd
);
  import rdp_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_MULQ  = 9'b000001000,
    S_MODR  = 9'b000010000,
    S_READ  = 9'b000100000,
    S_EVAL  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_RESP  = 9'b100000000
  } rdp_state_t;

  rdp_state_t state_r;
  rdp_state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid && in_func != FUNC_NONE) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_en = 1'b1;
        state_nxt   = S_MULQ;
      end
      S_MULQ: begin
        cmd.mulq_en = 1'b1;
        state_nxt   = S_MODR;
      end
      S_MODR: begin
        cmd.mod_en = 1'b1;
        state_nxt  = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.item_func inside {FUNC_PREDICT, FUNC_BYPASS}) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.wr_train = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/reuse_distance_predictor_top.sv -----
// ----------------------------------------------------------------------------
// reuse_distance_predictor_top
// Reuse distance predictor: a table of per-signature counters trained from
// sampled-cache outcomes, answering ETR predictions and bypass queries.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+------------------------
//   in_     | input     | in_valid / in_stall    | rdp_in_t  (operation)
//   out_    | output    | out_valid / out_stall  | rdp_out_t (ETR, bypass)
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Items are taken one at a time. Predict and bypass items pass through hash,
// index reduction, table read and the bit-serial ETR divider before the
// result hand-off; train items pass through hash, index reduction, table read
// and write back; unknown ops are taken without leaving idle. After reset the
// table is swept clear with in_stall high. A finished word waits in the output
// register; the next item is accepted while it is stalled.
// ----------------------------------------------------------------------------
module reuse_distance_predictor_top #(
  parameter int ENTRIES        = 2048,
  parameter int COUNTER_BITS   = 7,
  parameter int SIGNATURE_BITS = 11,
  parameter int TIMESTAMP_BITS = 8,
  parameter int RD_MARGIN      = 22
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rdp_pkg::rdp_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rdp_pkg::rdp_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rdp_pkg::*;

  rdp_cfg_t cfg_r;
  rdp_cmd_t cmd;
  rdp_sts_t sts;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.multi_core  <= MULTI_CORE_RST;
      cfg_r.granularity <= GRANULARITY_RST;
      cfg_r.inf_etr     <= INF_ETR_RST;
      cfg_r.max_etr     <= MAX_ETR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MULTI_CORE:  cfg_r.multi_core  <= cfg_data[0];
        CFG_GRANULARITY: cfg_r.granularity <= cfg_data[GRAN_W-1:0];
        CFG_INF_ETR:     cfg_r.inf_etr     <= cfg_data[ETR_W-1:0];
        CFG_MAX_ETR:     cfg_r.max_etr     <= cfg_data[ETR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdp_dp #(
    .ENTRIES        (ENTRIES),
    .COUNTER_BITS   (COUNTER_BITS),
    .SIGNATURE_BITS (SIGNATURE_BITS),
    .TIMESTAMP_BITS (TIMESTAMP_BITS),
    .RD_MARGIN      (RD_MARGIN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The table sweep holds the input off straight after reset
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("input accepted during table clear");

  // An unknown operation leaves the controller idle
  a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.func == FUNC_NONE) |=> !in_stall)
    else $error("unknown operation did not leave the block idle");

  // A bypass answer never carries an ETR
  a_bypass_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bypass) |-> (out_data.prediction == '0))
    else $error("bypass word with non-zero prediction");

endmodule
